[hdl/rsbdt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbdt_pkg: shared types for the date/time record sorter
// field widths, the stored record layout and the control/status bundles
// ----------------------------------------------------------------------------
package rsbdt_pkg;

  localparam int unsigned DateW = 20;
  localparam int unsigned TimeW = 14;
  localparam int unsigned TagW  = 32;
  localparam int unsigned KeyW  = DateW + TimeW;

  // one stored record: date in the upper key bits, time in the lower ones
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } rec_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic insert;  // place the incoming record into the chain
    logic drop;    // incoming record lost, chain full
    logic pop;     // head record taken, shift chain toward the head
    logic clear;   // run finished, clear the overflow flag
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;      // every cell holds a record
    logic head_last; // head is the only record left
  } sts_t;

endpackage

[hdl/rsbdt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbdt_if: request channels of the record sorter
// input record channel and sorted result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface rsbdt_in_if;
  logic                           valid;
  logic                           ready;
  logic [rsbdt_pkg::DateW-1:0]    rec_date;
  logic [rsbdt_pkg::TimeW-1:0]    rec_time;
  logic [rsbdt_pkg::TagW-1:0]     rec_tag;
  logic                           last_rec;

  modport source (output valid, rec_date, rec_time, rec_tag, last_rec, input ready);
  modport sink   (input valid, rec_date, rec_time, rec_tag, last_rec, output ready);
endinterface

interface rsbdt_out_if;
  logic                           valid;
  logic                           ready;
  logic [rsbdt_pkg::DateW-1:0]    sorted_date;
  logic [rsbdt_pkg::TimeW-1:0]    sorted_time;
  logic [rsbdt_pkg::TagW-1:0]     sorted_tag;
  logic                           last_sorted;
  logic                           overflow;

  modport source (output valid, sorted_date, sorted_time, sorted_tag, last_sorted, overflow,
                  input ready);
  modport sink   (input valid, sorted_date, sorted_time, sorted_tag, last_sorted, overflow,
                  output ready);
endinterface

[hdl/rsbdt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbdt_ctrl: load/emit controller
// takes records until the last one, then drains the sorted chain
// ----------------------------------------------------------------------------
module rsbdt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  input  logic              out_ready_i,
  input  rsbdt_pkg::sts_t   sts_i,
  output rsbdt_pkg::cmd_t   cmd_o,
  output logic              in_ready_o,
  output logic              out_valid_o
);

  localparam logic StLoad = 1'b0;
  localparam logic StEmit = 1'b1;

  logic state_q, state_d;
  logic in_acc, out_acc;

  assign in_ready_o  = (state_q == StLoad);
  assign out_valid_o = (state_q == StEmit);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;

  always_comb begin
    cmd_o        = '0;
    cmd_o.insert = in_acc & ~sts_i.full;
    cmd_o.drop   = in_acc & sts_i.full;
    cmd_o.pop    = out_acc;
    cmd_o.clear  = out_acc & sts_i.head_last;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad: begin
        if (in_acc && in_last_i) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_acc && sts_i.head_last) begin
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/rsbdt_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbdt_dpath: insertion chain datapath
// a row of cells kept sorted by key; shifts toward the head when draining
// ----------------------------------------------------------------------------
module rsbdt_dpath #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsbdt_pkg::cmd_t   cmd_i,
  input  rsbdt_pkg::rec_t   in_rec_i,
  output rsbdt_pkg::sts_t   sts_o,
  output rsbdt_pkg::rec_t   head_o,
  output logic              overflow_o
);

  rsbdt_pkg::rec_t  cell_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DEPTH-1:0] gt;
  logic             flag_q;

  // cells holding a strictly larger key move up; equal keys stay ahead
  always_comb begin
    for (int unsigned i = 0; i < DEPTH; i++) begin
      gt[i] = vld_q[i] & (cell_q[i].key > in_rec_i.key);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rsbdt_pkg::rec_t below_rec, above_rec, nxt;
    logic            below_vld, below_gt, above_vld, take_new, vld_d;

    if (i == 0) begin : g_head
      assign below_rec = in_rec_i;
      assign below_vld = 1'b1;
      assign below_gt  = 1'b0;
    end else begin : g_mid
      assign below_rec = cell_q[i-1];
      assign below_vld = vld_q[i-1];
      assign below_gt  = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign above_rec = cell_q[i];
      assign above_vld = 1'b0;
    end else begin : g_body
      assign above_rec = cell_q[i+1];
      assign above_vld = vld_q[i+1];
    end

    // first cell that is larger or empty, right after a kept record
    assign take_new = (gt[i] | ~vld_q[i]) & below_vld & ~below_gt;

    always_comb begin
      nxt   = cell_q[i];
      vld_d = vld_q[i];
      if (cmd_i.insert) begin
        if (below_gt) begin
          nxt   = below_rec;
          vld_d = 1'b1;
        end else if (take_new) begin
          nxt   = in_rec_i;
          vld_d = 1'b1;
        end
      end else if (cmd_i.pop) begin
        nxt   = above_rec;
        vld_d = above_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      cell_q[i] <= nxt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (cmd_i.drop) begin
      flag_q <= 1'b1;
    end else if (cmd_i.clear) begin
      flag_q <= 1'b0;
    end
  end

  assign head_o         = cell_q[0];
  assign overflow_o     = flag_q;
  assign sts_o.full     = vld_q[DEPTH-1];
  assign sts_o.head_last = ~vld_q[1];

endmodule

[hdl/record_sort_by_date_time.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_sort_by_date_time: two-key record sorter
// loads records, then emits them ascending by date, then by time
// ----------------------------------------------------------------------------
// Records enter on in_i one per cycle while the block is loading; each one is
// dropped into its place in a chain of DEPTH insertion cells, so the chain is
// always sorted by date and then time, with equal keys in arrival order. A
// record arriving with all cells full is lost and the overflow flag is set.
// Taking the record marked last_rec switches the block to draining: the head
// cell drives out_o and the chain shifts one place per taken request, so a
// run of n records leaves as n results. last_sorted marks the final one and
// overflow holds the same value across the whole run. While draining, in_ready
// is low; after the final request the chain is empty and the block loads again
// on the next cycle. Throughput is set by the chain: one insertion compare per
// cell per cycle while loading, one shift per cycle while draining and out_o
// ready is high.
// ----------------------------------------------------------------------------
module record_sort_by_date_time #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsbdt_in_if.sink    in_i,
  rsbdt_out_if.source out_o
);

  rsbdt_pkg::cmd_t cmd;
  rsbdt_pkg::sts_t sts;
  rsbdt_pkg::rec_t in_rec, head;
  logic            overflow;

  // key is date over time, so one compare orders both fields
  assign in_rec.key = {in_i.rec_date, in_i.rec_time};
  assign in_rec.tag = in_i.rec_tag;

  // sequencing: load until the last request, then drain
  rsbdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_rec),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid)
  );

  // sorted insertion chain plus overflow flag
  rsbdt_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_rec_i  (in_rec),
    .sts_o     (sts),
    .head_o    (head),
    .overflow_o(overflow)
  );

  // head cell is a register, so the result payload comes straight from it
  assign out_o.sorted_date = head.key[rsbdt_pkg::KeyW-1:rsbdt_pkg::TimeW];
  assign out_o.sorted_time = head.key[rsbdt_pkg::TimeW-1:0];
  assign out_o.sorted_tag  = head.tag;
  assign out_o.last_sorted = sts.head_last;
  assign out_o.overflow    = overflow;

  // loading and draining never overlap
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input and output both open");

  // the last request starts draining on the next cycle
  a_last_starts_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last_rec) |=> out_o.valid)
    else $error("drain did not start after last request");

  // the final result returns the block to loading with an empty chain
  a_end_of_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_sorted) |=> (in_i.ready && !sts.full))
    else $error("block not back to loading after final result");

  // overflow is fixed for the whole run
  a_overflow_steady : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && $past(out_o.valid)) |-> $stable(out_o.overflow))
    else $error("overflow changed within a run");

endmodule
